FILE: hdl/ecr_pkg.sv
package ecr_pkg;

    localparam logic ACT_CLASSIFY = 1'b0;
    localparam logic ACT_WRITE    = 1'b1;

    localparam logic [1:0] VERDICT_DROP       = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT     = 2'd1;
    localparam logic [1:0] VERDICT_PIPELINE   = 2'd2;
    localparam logic [1:0] VERDICT_WRITE_DONE = 2'd3;

    localparam logic [7:0] CODE_DROP   = 8'd0;
    localparam logic [7:0] CODE_ACCEPT = 8'd1;

    localparam int MASK_SRC_IP   = 0;
    localparam int MASK_DST_IP   = 1;
    localparam int MASK_SRC_PORT = 2;
    localparam int MASK_DST_PORT = 3;
    localparam int MASK_PROTOCOL = 4;

    localparam logic [4:0] MASK_RESET = 5'd31;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } key_t;

    typedef struct packed {
        logic        action;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [15:0] packet_length;
        logic [5:0]  entry_slot;
        logic        entry_valid;
        logic [7:0]  entry_verdict;
        logic [7:0]  entry_rule;
    } req_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        hit;
        logic [7:0]  matched_rule;
        logic [63:0] packet_total;
        logic [63:0] byte_total;
    } rsp_t;

    typedef struct packed {
        logic [4:0] key_field_mask;
    } cfg_t;

    typedef struct packed {
        key_t       key;
        logic [7:0] code;
        logic [7:0] rule;
    } entry_t;

    typedef struct packed {
        logic       valid;
        logic       found;
        key_t       key;
        logic [7:0] code;
        logic [7:0] rule;
    } tok_t;

endpackage

FILE: hdl/ecr_chan_if.sv
interface ecr_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ecr_ram.sv
module ecr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/ecr_cell.sv
module ecr_cell
    import ecr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] mask,
    input  logic       wr_en,
    input  logic       wr_valid,
    input  entry_t     wr_entry,
    input  tok_t       tok_in,
    output tok_t       tok_out
);

    logic   in_use_reg;
    entry_t entry_reg;
    logic   valid_reg;
    logic   found_reg;
    key_t   key_reg;
    logic [7:0] code_reg;
    logic [7:0] rule_reg;
    logic   match;
    logic   take;

    assign match = (!mask[MASK_SRC_IP]   || entry_reg.key.src_ip   == tok_in.key.src_ip)
                && (!mask[MASK_DST_IP]   || entry_reg.key.dst_ip   == tok_in.key.dst_ip)
                && (!mask[MASK_SRC_PORT] || entry_reg.key.src_port == tok_in.key.src_port)
                && (!mask[MASK_DST_PORT] || entry_reg.key.dst_port == tok_in.key.dst_port)
                && (!mask[MASK_PROTOCOL] || entry_reg.key.protocol == tok_in.key.protocol);

    assign take = !tok_in.found && in_use_reg && match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
            if (wr_en)
            begin
                in_use_reg <= wr_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_valid)
        begin
            entry_reg <= wr_entry;
        end
        key_reg   <= tok_in.key;
        found_reg <= tok_in.found || take;
        code_reg  <= take ? entry_reg.code : tok_in.code;
        rule_reg  <= take ? entry_reg.rule : tok_in.rule;
    end

    assign tok_out = '{valid: valid_reg, found: found_reg, key: key_reg,
                       code: code_reg, rule: rule_reg};

endmodule

FILE: hdl/exact_match_rule_classifier.sv
// Exact-match packet pre-classifier. One request is handled at a time. A
// write request installs or removes a table entry. A packet request walks
// a row of RULE_SLOTS match cells, one cell per cycle; a counted hit then
// adds a read-modify-write of the counter memory, which a miss or an
// out-of-range rule skips. After reset the counter memory is cleared in a
// pass during which no request is taken; the key mask may be written during
// that pass, and otherwise only while no request is in flight.
module exact_match_rule_classifier
    import ecr_pkg::*;
#(
    parameter int RULE_SLOTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ecr_chan_if.sink   cfg,
    ecr_chan_if.sink   pkt,
    ecr_chan_if.source result
);

    localparam int SLOT_W = $clog2(RULE_SLOTS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_COUNT  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [SLOT_W-1:0] clr_addr_reg;
    logic [4:0]        mask_reg;
    logic [15:0]       len_reg;
    logic [7:0]        code_reg;
    logic [7:0]        rule_reg;
    logic [SLOT_W-1:0] cnt_addr_reg;
    rsp_t              res_reg;
    rsp_t              res_next;
    rsp_t              out_reg;
    logic              out_valid_reg;

    tok_t              chain [RULE_SLOTS+1];
    logic [RULE_SLOTS-1:0] tok_valid;
    logic [RULE_SLOTS-1:0] cell_wr;
    entry_t            wr_entry;
    tok_t              tail;

    logic              accept;
    logic              in_range;
    logic [SLOT_W+7:0] rule_ext;
    logic [SLOT_W-1:0] rule_addr;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [127:0]      ram_wdata;
    logic [127:0]      ram_rdata;
    logic [63:0]       pkt_sum;
    logic [63:0]       byte_sum;
    logic              res_load;
    logic              out_free;

    function automatic logic [1:0] code_to_verdict(input logic [7:0] code);
        logic [1:0] v;
        case (code)
            CODE_DROP:   v = VERDICT_DROP;
            CODE_ACCEPT: v = VERDICT_ACCEPT;
            default:     v = VERDICT_PIPELINE;
        endcase
        return v;
    endfunction

    assign cfg.ready = 1'b1;
    assign pkt.ready = (state_reg == ST_IDLE);
    assign accept    = pkt.valid && pkt.ready;

    assign wr_entry.key.src_ip   = pkt.payload.src_ip;
    assign wr_entry.key.dst_ip   = pkt.payload.dst_ip;
    assign wr_entry.key.src_port = pkt.payload.src_port;
    assign wr_entry.key.dst_port = pkt.payload.dst_port;
    assign wr_entry.key.protocol = pkt.payload.protocol;
    assign wr_entry.code         = pkt.payload.entry_verdict;
    assign wr_entry.rule         = pkt.payload.entry_rule;

    assign chain[0].valid = accept && (pkt.payload.action == ACT_CLASSIFY);
    assign chain[0].found = 1'b0;
    assign chain[0].key   = wr_entry.key;
    assign chain[0].code  = CODE_DROP;
    assign chain[0].rule  = 8'd0;

    for (genvar i = 0; i < RULE_SLOTS; i++)
    begin : g_cell
        assign cell_wr[i] = accept && (pkt.payload.action == ACT_WRITE)
                         && (32'(pkt.payload.entry_slot) == 32'(i));
        assign tok_valid[i] = chain[i+1].valid;

        ecr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .mask     (mask_reg),
            .wr_en    (cell_wr[i]),
            .wr_valid (pkt.payload.entry_valid),
            .wr_entry (wr_entry),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    assign tail      = chain[RULE_SLOTS];
    assign in_range  = {24'd0, tail.rule} < 32'(RULE_SLOTS);
    assign rule_ext  = {{SLOT_W{1'b0}}, tail.rule};
    assign rule_addr = rule_ext[SLOT_W-1:0];

    assign pkt_sum  = ram_rdata[127:64] + 64'd1;
    assign byte_sum = ram_rdata[63:0] + 64'(len_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_addr_reg;
        ram_wdata = {pkt_sum, byte_sum};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_COUNT)
        begin
            ram_we = 1'b1;
        end
    end

    ecr_ram #(
        .WIDTH (128),
        .DEPTH (RULE_SLOTS)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rule_addr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        res_next   = '{verdict: VERDICT_PIPELINE, hit: 1'b0, matched_rule: 8'd0,
                       packet_total: 64'd0, byte_total: 64'd0};
        res_load   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == SLOT_W'(RULE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pkt.payload.action == ACT_WRITE)
                    begin
                        res_next.verdict = VERDICT_WRITE_DONE;
                        res_load   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tail.valid)
                begin
                    if (tail.found && in_range)
                    begin
                        state_next = ST_COUNT;
                    end
                    else
                    begin
                        res_next.hit          = tail.found;
                        res_next.matched_rule = tail.rule;
                        res_load   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_COUNT:
            begin
                res_next.verdict      = code_to_verdict(code_reg);
                res_next.hit          = 1'b1;
                res_next.matched_rule = rule_reg;
                res_next.packet_total = pkt_sum;
                res_next.byte_total   = byte_sum;
                res_load   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            end
            if (cfg.valid && cfg.ready)
            begin
                mask_reg <= cfg.payload.key_field_mask;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg <= pkt.payload.packet_length;
        end
        if (state_reg == ST_SEARCH)
        begin
            code_reg     <= tail.code;
            rule_reg     <= tail.rule;
            cnt_addr_reg <= rule_addr;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    a_tail_in_search : assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == ST_SEARCH)
        else $error("search result left the cell row outside the search state");

    a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one packet in the cell row");

    a_count_after_search : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COUNT |-> $past(state_reg) == ST_SEARCH)
        else $error("counter update not preceded by a search");

    a_no_request_during_clear : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !chain[0].valid && cell_wr == '0)
        else $error("request taken while the counters are being cleared");

endmodule
